>>> hw/rtl/stcci_pkg.sv
// Package for the 90 percent Student t confidence interval block.
// Holds request/result/job types, critical-value tables and pipeline widths.
// No dependencies.
`default_nettype none

package stcci_pkg;

  // Widths of the arithmetic datapath
  localparam int unsigned T_W    = 13;  // critical value in thousandths
  localparam int unsigned TT_W   = 26;  // t squared
  localparam int unsigned DEN_W  = 52;  // 1e6 * (n - 1)
  localparam int unsigned PROD_W = 50;  // t squared times one 24-bit half of the variance
  localparam int unsigned RHS_W  = 90;  // t^2 * var * 2^16
  localparam int unsigned Q_W    = 71;  // quotient rhs / den
  localparam int unsigned SQ_W   = 72;  // quotient padded to even width
  localparam int unsigned ROOT_W = 36;  // half width
  localparam int unsigned SREM_W = 38;  // square-root remainder

  localparam logic [T_W-1:0] T_LARGE_N = 13'd1645;
  localparam logic [T_W-1:0] T_N_1000  = 13'd1646;
  localparam logic [T_W-1:0] T_N_100   = 13'd1660;

  typedef struct packed {
    logic        [31:0] sample_count;
    logic signed [47:0] sample_mean;
    logic        [47:0] sample_variance;
  } stcci_in_t;

  typedef struct packed {
    logic signed [47:0] low_bound;
    logic signed [47:0] upper_bound;
    logic               count_invalid;
  } stcci_out_t;

  // Classified job passed from front to back
  typedef struct packed {
    logic [T_W-1:0]     t_crit;
    logic [31:0]        n_less1;
    logic signed [47:0] mean;
    logic [47:0]        variance;
    logic               zero_width;
    logic               invalid;
  } stcci_job_t;

  // Fields carried alongside the arithmetic
  typedef struct packed {
    logic signed [47:0] mean;
    logic               invalid;
    logic               zero_width;
  } stcci_side_t;

  // Dense critical values for n below 30
  function automatic logic [T_W-1:0] dense_t(input logic [4:0] idx);
    logic [T_W-1:0] v;
    case (idx)
      5'd1:    v = 13'd6314;
      5'd2:    v = 13'd2920;
      5'd3:    v = 13'd2353;
      5'd4:    v = 13'd2132;
      5'd5:    v = 13'd2015;
      5'd6:    v = 13'd1943;
      5'd7:    v = 13'd1895;
      5'd8:    v = 13'd1860;
      5'd9:    v = 13'd1833;
      5'd10:   v = 13'd1812;
      5'd11:   v = 13'd1796;
      5'd12:   v = 13'd1782;
      5'd13:   v = 13'd1771;
      5'd14:   v = 13'd1761;
      5'd15:   v = 13'd1753;
      5'd16:   v = 13'd1746;
      5'd17:   v = 13'd1740;
      5'd18:   v = 13'd1734;
      5'd19:   v = 13'd1729;
      5'd20:   v = 13'd1725;
      5'd21:   v = 13'd1721;
      5'd22:   v = 13'd1717;
      5'd23:   v = 13'd1714;
      5'd24:   v = 13'd1711;
      5'd25:   v = 13'd1708;
      5'd26:   v = 13'd1706;
      5'd27:   v = 13'd1703;
      5'd28:   v = 13'd1701;
      5'd29:   v = 13'd1699;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Sparse critical values at n = 30, 40, ..., 100
  function automatic logic [T_W-1:0] sparse_t(input logic [2:0] idx);
    logic [T_W-1:0] v;
    case (idx)
      3'd0:    v = 13'd1697;
      3'd1:    v = 13'd1684;
      3'd2:    v = 13'd1676;
      3'd3:    v = 13'd1671;
      3'd4:    v = 13'd1667;
      3'd5:    v = 13'd1664;
      3'd6:    v = 13'd1662;
      default: v = 13'd1660;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stcci_front.sv
// Front end: accepts requests and classifies them into jobs with a critical value.
// Depends on stcci_pkg.
`default_nettype none

module stcci_front import stcci_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire stcci_in_t  req,
  output logic            job_valid,
  output stcci_job_t      job
);

  logic           job_valid_r, job_valid_nxt;
  stcci_job_t     job_r, job_nxt;
  logic [31:0]    n;
  logic [6:0]     x_mid;
  logic [2:0]     seg;
  logic [3:0]     j_mid;
  logic [T_W-1:0] v_lo, v_hi;
  logic [3:0]     drop;
  logic [7:0]     y_mid;
  logic [3:0]     c_mid;
  logic [9:0]     j_long;
  logic [13:0]    y_long;
  logic [4:0]     c_long;
  logic [T_W-1:0] t_sel;

  // Look up or interpolate the critical value
  always_comb begin
    n      = req.sample_count;
    x_mid  = n[6:0] - 7'd30;
    seg    = 3'((14'(x_mid) * 14'd205) >> 11);
    j_mid  = 4'(x_mid - 7'(seg) * 7'd10);
    v_lo   = sparse_t(seg);
    v_hi   = sparse_t(seg + 3'd1);
    drop   = 4'(v_lo - v_hi);
    y_mid  = 8'(8'(j_mid) * 8'(drop)) + 8'd9;
    c_mid  = 4'((16'(y_mid) * 16'd205) >> 11);
    j_long = n[9:0] - 10'd100;
    y_long = 14'(14'(j_long) * 14'd14) + 14'd899;
    c_long = 5'((29'(y_long) * 29'd18642) >> 24);
    if (n < 32'd30) begin
      t_sel = dense_t(n[4:0]);
    end else if (n > 32'd1000) begin
      t_sel = T_LARGE_N;
    end else if (n == 32'd1000) begin
      t_sel = T_N_1000;
    end else if (n == 32'd100) begin
      t_sel = T_N_100;
    end else if (n < 32'd100) begin
      t_sel = v_lo - T_W'(c_mid);
    end else begin
      t_sel = T_N_100 - T_W'(c_long);
    end
    job_nxt.t_crit     = t_sel;
    job_nxt.n_less1    = n - 32'd1;
    job_nxt.mean       = req.sample_mean;
    job_nxt.variance   = req.sample_variance;
    job_nxt.zero_width = (n <= 32'd1);
    job_nxt.invalid    = (n == 32'd0);
    job_valid_nxt      = accept;
  end

  // Register the classified job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
    end
    job_r <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

`default_nettype wire

>>> hw/rtl/stcci_queue.sv
// Two-entry job queue between front end and back end.
// Depends on stcci_pkg.
`default_nettype none

module stcci_queue import stcci_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire stcci_job_t push_job,
  input  wire logic       pop,
  output logic            not_empty,
  output logic            full,
  output stcci_job_t      head
);

  localparam int unsigned DEPTH = 2;

  stcci_job_t  entry_r [DEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  // Advance pointers and count
  always_comb begin
    do_push    = push && (cnt_r != 2'(DEPTH));
    do_pop     = pop && (cnt_r != 2'd0);
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'(DEPTH));
  assign head      = entry_r[rd_ptr_r];

  // Catch overflow, count range, fill without a push
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("job queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(DEPTH))
    else $error("job queue count out of range");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) && !push |=> (cnt_r == 2'd0))
    else $error("job queue filled without a push");

endmodule

`default_nettype wire

>>> hw/rtl/stcci_back.sv
// Back end: product, pipelined restoring division and pipelined square root,
// then the saturated bounds. Depends on stcci_pkg.
`default_nettype none

module stcci_back import stcci_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_valid,
  input  wire stcci_job_t job,
  output logic            res_valid,
  output stcci_out_t      res
);

  localparam int unsigned SQ_STEPS = SQ_W / 2;

  // Multiply stages
  logic               b0_valid_r, b1_valid_r, b2_valid_r;
  logic [TT_W-1:0]    b0_tt_r;
  logic [DEN_W-1:0]   b0_den_r, b1_den_r, b2_den_r;
  logic [47:0]        b0_var_r;
  stcci_side_t        b0_side_r, b1_side_r, b2_side_r;
  logic [PROD_W-1:0]  b1_plo_r, b1_phi_r;
  logic [RHS_W-1:0]   b2_rhs_r;
  logic [DEN_W-1:0]   den_nxt;
  logic [RHS_W-1:0]   rhs_nxt;

  // Division stages
  logic               dv_valid_r [Q_W+1];
  logic [DEN_W-1:0]   dv_rem_r   [Q_W+1];
  logic [Q_W-1:0]     dv_qn_r    [Q_W+1];
  logic [DEN_W-1:0]   dv_den_r   [Q_W+1];
  stcci_side_t        dv_side_r  [Q_W+1];

  // Square-root stages
  logic               sq_valid_r [SQ_STEPS+1];
  logic [SQ_W-1:0]    sq_x_r     [SQ_STEPS+1];
  logic [SREM_W-1:0]  sq_rem_r   [SQ_STEPS+1];
  logic [ROOT_W-1:0]  sq_root_r  [SQ_STEPS+1];
  stcci_side_t        sq_side_r  [SQ_STEPS+1];

  // Result stage
  logic               res_valid_r;
  stcci_out_t         res_r, res_nxt;
  logic signed [49:0] mean_ext, h_ext, lo_sum, hi_sum;

  localparam logic signed [49:0] SMAX = 50'sh7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SMIN = -SMAX - 50'sd1;

  assign den_nxt = job.zero_width ? DEN_W'(1) : DEN_W'(job.n_less1) * DEN_W'(1000000);
  assign rhs_nxt = b1_side_r.zero_width ? '0 :
                   RHS_W'({(PROD_W+24)'(b1_phi_r) << 24} + (PROD_W+24)'(b1_plo_r)) << 16;

  // Advance multiply stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_valid_r <= 1'b0;
      b1_valid_r <= 1'b0;
      b2_valid_r <= 1'b0;
    end else begin
      b0_valid_r <= job_valid;
      b1_valid_r <= b0_valid_r;
      b2_valid_r <= b1_valid_r;
    end
    b0_tt_r              <= TT_W'(job.t_crit) * TT_W'(job.t_crit);
    b0_den_r             <= den_nxt;
    b0_var_r             <= job.variance;
    b0_side_r.mean       <= job.mean;
    b0_side_r.invalid    <= job.invalid;
    b0_side_r.zero_width <= job.zero_width;
    b1_plo_r             <= PROD_W'(b0_tt_r) * PROD_W'(b0_var_r[23:0]);
    b1_phi_r             <= PROD_W'(b0_tt_r) * PROD_W'(b0_var_r[47:24]);
    b1_den_r             <= b0_den_r;
    b1_side_r            <= b0_side_r;
    b2_rhs_r             <= rhs_nxt;
    b2_den_r             <= b1_den_r;
    b2_side_r            <= b1_side_r;
  end

  // Load division from the product stage
  always_comb begin
    dv_valid_r[0] = b2_valid_r;
    dv_rem_r[0]   = DEN_W'(b2_rhs_r[RHS_W-1:Q_W]);
    dv_qn_r[0]    = b2_rhs_r[Q_W-1:0];
    dv_den_r[0]   = b2_den_r;
    dv_side_r[0]  = b2_side_r;
  end

  // One quotient bit per stage
  for (genvar s = 0; s < Q_W; s++) begin : g_div
    logic [DEN_W:0] wide, diff;
    logic           ge;
    always_comb begin
      wide = {dv_rem_r[s], dv_qn_r[s][Q_W-1]};
      diff = wide - {1'b0, dv_den_r[s]};
      ge   = (wide >= {1'b0, dv_den_r[s]});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[s+1] <= 1'b0;
      end else begin
        dv_valid_r[s+1] <= dv_valid_r[s];
      end
      dv_rem_r[s+1]  <= ge ? diff[DEN_W-1:0] : wide[DEN_W-1:0];
      dv_qn_r[s+1]   <= {dv_qn_r[s][Q_W-2:0], ge};
      dv_den_r[s+1]  <= dv_den_r[s];
      dv_side_r[s+1] <= dv_side_r[s];
    end
  end

  // Load square root from the quotient
  always_comb begin
    sq_valid_r[0] = dv_valid_r[Q_W];
    sq_x_r[0]     = SQ_W'(dv_qn_r[Q_W]);
    sq_rem_r[0]   = '0;
    sq_root_r[0]  = '0;
    sq_side_r[0]  = dv_side_r[Q_W];
  end

  // One root bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [SREM_W:0] r2, trial, diff;
    logic            ge;
    always_comb begin
      r2    = {sq_rem_r[k][SREM_W-2:0], sq_x_r[k][SQ_W-1:SQ_W-2]};
      trial = (SREM_W+1)'({sq_root_r[k], 2'b01});
      diff  = r2 - trial;
      ge    = (r2 >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k+1] <= 1'b0;
      end else begin
        sq_valid_r[k+1] <= sq_valid_r[k];
      end
      sq_x_r[k+1]    <= {sq_x_r[k][SQ_W-3:0], 2'b00};
      sq_rem_r[k+1]  <= ge ? diff[SREM_W-1:0] : r2[SREM_W-1:0];
      sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], ge};
      sq_side_r[k+1] <= sq_side_r[k];
    end
  end

  // Form and saturate the bounds
  always_comb begin
    mean_ext = 50'(sq_side_r[SQ_STEPS].mean);
    h_ext    = $signed({14'd0, sq_root_r[SQ_STEPS]});
    lo_sum   = mean_ext - h_ext;
    hi_sum   = mean_ext + h_ext;
    res_nxt.low_bound     = (lo_sum < SMIN) ? 48'(SMIN) : 48'(lo_sum);
    res_nxt.upper_bound   = (hi_sum > SMAX) ? 48'(SMAX) : 48'(hi_sum);
    res_nxt.count_invalid = sq_side_r[SQ_STEPS].invalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= sq_valid_r[SQ_STEPS];
    end
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

>>> hw/rtl/student_t_confidence_interval.sv
// Top level of the 90 percent Student t confidence interval block.
// Depends on stcci_pkg, stcci_front, stcci_queue and stcci_back.
//
// Usage:
//   A request (sample count, Q.16 mean, Q.16 variance) is taken on a rising
//   edge with start high and busy low. Exactly one result per request leaves
//   on out_data, marked by out_strobe for a single cycle; the receiver must
//   take it then, it cannot stall the block.
//   Path: from request to result through the front-end register, the job
//   queue register, three multiply stages, 71 division stages (one quotient
//   bit each), 36 square-root stages (one root bit each) and the output
//   register.
//   Throughput: one request per cycle while busy is low; the back end is fully
//   pipelined and drains the queue every cycle, so busy only rises if the queue fills.
//   Reset (rst_n low, synchronous) empties the queue and clears all stage
//   valid flags; requests in flight are dropped.
`default_nettype none

module student_t_confidence_interval import stcci_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire stcci_in_t  in_data,
  output logic            out_strobe,
  output stcci_out_t      out_data
);

  logic       accept;
  logic       fe_valid;
  stcci_job_t fe_job;
  logic       q_not_empty, q_full;
  stcci_job_t q_head;

  assign accept = start && !busy;
  assign busy   = q_full;

  stcci_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req       (in_data),
    .job_valid (fe_valid),
    .job       (fe_job)
  );

  stcci_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_valid),
    .push_job  (fe_job),
    .pop       (q_not_empty),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (q_head)
  );

  stcci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job       (q_head),
    .res_valid (out_strobe),
    .res       (out_data)
  );

  // Invalid count gives the mean on both sides
  a_invalid_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.count_invalid |->
      out_data.low_bound == out_data.upper_bound)
    else $error("invalid count with unequal bounds");
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.low_bound <= out_data.upper_bound)
    else $error("lower bound above upper bound");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire
